// File: hw/rtl/bfa_pkg.sv
package bfa_pkg;

    localparam int FRAME_COUNT = 256;
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = 5;
    localparam int FRAME_SHIFT = 10;
    localparam int MAX_REQUEST = 64;
    localparam int ADDR_W      = 18;
    localparam int COUNT_W     = 8;
    localparam int TOTAL_W     = 9;
    localparam int REG_W       = 9;
    localparam int REQ_W       = 7;
    localparam int FNUM_W      = ADDR_W - FRAME_SHIFT;

    localparam logic [REG_W-1:0] RESET_FRAMES = 9'd256;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [REQ_W-1:0]  request_count;
        logic [ADDR_W-1:0] free_address;
    } t_bfa_request;

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  frame_address;
        logic [COUNT_W-1:0] free_count;
        logic               last;
    } t_bfa_result;

    typedef enum logic [2:0] {
        KIND_ALLOC,
        KIND_FREE,
        KIND_SHORT,
        KIND_BAD,
        KIND_NOP
    } t_bfa_kind;

    typedef struct packed {
        t_bfa_kind         kind;
        logic [REQ_W-1:0]  count;
        logic [FNUM_W-1:0] frame;
    } t_bfa_cmd;

    typedef struct packed {
        logic             init;
        logic [REG_W-1:0] managed;
    } t_bfa_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } t_bfa_state;

    function automatic logic [REG_W-1:0] clamp_frames(input logic [REG_W-1:0] value,
                                                      input int frame_count);
        int n;
        n = int'(value);
        if (n < 2) n = 2;
        if (n > frame_count) n = frame_count;
        return REG_W'(n);
    endfunction

endpackage

// File: hw/rtl/bfa_front.sv
module bfa_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  bfa_pkg::t_bfa_request i_request,
    output logic                  busy,
    input  bfa_pkg::t_bfa_cfg     i_cfg,
    input  logic                  i_pop,
    output logic                  o_empty,
    output bfa_pkg::t_bfa_cmd     o_head
);

    bfa_pkg::t_bfa_cmd r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              n_wp;
    logic              n_rp;
    logic [1:0]        n_cnt;

    bfa_pkg::t_bfa_cmd          cmd;
    logic [bfa_pkg::FNUM_W-1:0] fnum;
    logic                       push;

    assign busy    = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_q[r_rp];
    assign push    = start && !busy;
    assign fnum    = i_request.free_address[bfa_pkg::ADDR_W-1:bfa_pkg::FRAME_SHIFT];

    // sort the request before it is queued
    always_comb begin
        cmd.count = i_request.request_count;
        cmd.frame = fnum;
        if (i_request.opcode == bfa_pkg::OP_ALLOC) begin
            if (i_request.request_count > bfa_pkg::REQ_W'(bfa_pkg::MAX_REQUEST)) begin
                cmd.kind = bfa_pkg::KIND_SHORT;
            end else if (i_request.request_count == '0) begin
                cmd.kind = bfa_pkg::KIND_NOP;
            end else begin
                cmd.kind = bfa_pkg::KIND_ALLOC;
            end
        end else begin
            if (fnum == '0 || {1'b0, fnum} >= i_cfg.managed) begin
                cmd.kind = bfa_pkg::KIND_BAD;
            end else begin
                cmd.kind = bfa_pkg::KIND_FREE;
            end
        end
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

// File: hw/rtl/bfa_back.sv
module bfa_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bfa_pkg::t_bfa_cfg    i_cfg,
    input  logic                 i_empty,
    input  bfa_pkg::t_bfa_cmd    i_head,
    output logic                 o_pop,
    output logic                 o_result_strobe,
    output bfa_pkg::t_bfa_result o_result
);

    localparam int WORDS  =
        (bfa_pkg::FRAME_COUNT + bfa_pkg::WORD_BITS - 1) / bfa_pkg::WORD_BITS;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FIDX_W = WIDX_W + bfa_pkg::BIT_W;
    localparam int WB     = bfa_pkg::WORD_BITS;

    localparam logic [bfa_pkg::REG_W-1:0] RESET_MANAGED =
        bfa_pkg::clamp_frames(bfa_pkg::RESET_FRAMES, bfa_pkg::FRAME_COUNT);

    logic [WB-1:0] r_mem [WORDS];
    logic [WB-1:0] r_rdata;

    bfa_pkg::t_bfa_state          r_state;
    bfa_pkg::t_bfa_state          n_state;
    logic [WORDS-1:0]             r_valid;
    logic [WIDX_W-1:0]            r_hint;
    logic [WIDX_W-1:0]            n_hint;
    logic [bfa_pkg::TOTAL_W-1:0]  r_total;
    logic [bfa_pkg::TOTAL_W-1:0]  n_total;
    logic                         r_strobe;
    logic                         n_strobe;
    bfa_pkg::t_bfa_result         r_result;
    bfa_pkg::t_bfa_result         n_result;
    logic [WIDX_W-1:0]            r_ptr;
    logic [WIDX_W-1:0]            n_ptr;
    logic [bfa_pkg::REQ_W-1:0]    r_count;
    logic [bfa_pkg::REQ_W-1:0]    n_count;
    logic [bfa_pkg::BIT_W-1:0]    r_bitpos;
    logic [bfa_pkg::BIT_W-1:0]    n_bitpos;
    logic                         r_is_free;
    logic                         n_is_free;

    logic                         rd_en;
    logic                         mem_we;
    logic [WB-1:0]                mem_wdata;
    logic [WB-1:0]                init_word;
    logic [WB-1:0]                word_cur;
    logic [bfa_pkg::BIT_W-1:0]    low_bit;
    logic [FIDX_W-1:0]            frame_idx;
    logic [31:0]                  addr_wide;
    logic [31:0]                  head_word;

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    // a word never written since init reads as frame zero used, managed frames free
    always_comb begin
        logic [FIDX_W-1:0] idx;
        for (int b = 0; b < WB; b++) begin
            idx          = {r_ptr, bfa_pkg::BIT_W'(b)};
            init_word[b] = (idx != '0) && (32'(idx) < 32'(i_cfg.managed));
        end
    end

    assign word_cur = r_valid[r_ptr] ? r_rdata : init_word;

    always_comb begin
        low_bit = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (word_cur[b]) low_bit = bfa_pkg::BIT_W'(b);
        end
    end

    assign frame_idx = {r_ptr, low_bit};
    assign addr_wide = 32'(frame_idx) << bfa_pkg::FRAME_SHIFT;
    assign head_word = 32'(i_head.frame) >> bfa_pkg::BIT_W;

    always_comb begin
        n_state   = r_state;
        n_hint    = r_hint;
        n_total   = r_total;
        n_strobe  = 1'b0;
        n_result  = r_result;
        n_ptr     = r_ptr;
        n_count   = r_count;
        n_bitpos  = r_bitpos;
        n_is_free = r_is_free;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = word_cur;

        unique case (r_state)
            bfa_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop                  = 1'b1;
                    n_result.frame_address = '0;
                    n_result.free_count    = r_total[bfa_pkg::COUNT_W-1:0];
                    n_result.last          = 1'b1;
                    unique case (i_head.kind)
                        bfa_pkg::KIND_SHORT: begin
                            n_strobe        = 1'b1;
                            n_result.status = bfa_pkg::STATUS_SHORT;
                        end
                        bfa_pkg::KIND_BAD: begin
                            n_strobe        = 1'b1;
                            n_result.status = bfa_pkg::STATUS_BAD;
                        end
                        bfa_pkg::KIND_NOP: begin
                            n_strobe        = 1'b1;
                            n_result.status = bfa_pkg::STATUS_OK;
                        end
                        bfa_pkg::KIND_ALLOC: begin
                            if (bfa_pkg::TOTAL_W'(i_head.count) > r_total) begin
                                n_strobe        = 1'b1;
                                n_result.status = bfa_pkg::STATUS_SHORT;
                            end else begin
                                n_count   = i_head.count;
                                n_ptr     = r_hint;
                                n_is_free = 1'b0;
                                n_state   = bfa_pkg::ST_READ;
                            end
                        end
                        bfa_pkg::KIND_FREE: begin
                            n_ptr     = head_word[WIDX_W-1:0];
                            n_bitpos  = i_head.frame[bfa_pkg::BIT_W-1:0];
                            n_is_free = 1'b1;
                            n_state   = bfa_pkg::ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            bfa_pkg::ST_READ: begin
                rd_en   = 1'b1;
                n_state = bfa_pkg::ST_CHECK;
            end
            bfa_pkg::ST_CHECK: begin
                if (r_is_free) begin
                    mem_we    = 1'b1;
                    mem_wdata = word_cur | (WB'(1) << r_bitpos);
                    if (!word_cur[r_bitpos]) begin
                        n_total = r_total + 1'b1;
                    end
                    if (r_ptr < r_hint) begin
                        n_hint = r_ptr;
                    end
                    n_strobe               = 1'b1;
                    n_result.status        = bfa_pkg::STATUS_OK;
                    n_result.frame_address = '0;
                    n_result.free_count    = n_total[bfa_pkg::COUNT_W-1:0];
                    n_result.last          = 1'b1;
                    n_state                = bfa_pkg::ST_IDLE;
                end else if (word_cur == '0) begin
                    // all frames of this word taken, move on
                    n_ptr   = r_ptr + 1'b1;
                    n_state = bfa_pkg::ST_READ;
                end else begin
                    mem_we                 = 1'b1;
                    mem_wdata              = word_cur & ~(WB'(1) << low_bit);
                    n_total                = r_total - 1'b1;
                    n_count                = r_count - 1'b1;
                    n_hint                 = r_ptr;
                    n_strobe               = 1'b1;
                    n_result.status        = bfa_pkg::STATUS_OK;
                    n_result.frame_address = addr_wide[bfa_pkg::ADDR_W-1:0];
                    n_result.free_count    = n_total[bfa_pkg::COUNT_W-1:0];
                    n_result.last          = (r_count == bfa_pkg::REQ_W'(1));
                    n_state = (r_count == bfa_pkg::REQ_W'(1)) ? bfa_pkg::ST_IDLE
                                                               : bfa_pkg::ST_READ;
                end
            end
            default: begin
                n_state = bfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bfa_pkg::ST_IDLE;
            r_valid  <= '0;
            r_hint   <= '0;
            r_total  <= RESET_MANAGED - 1'b1;
            r_strobe <= 1'b0;
        end else if (i_cfg.init) begin
            r_state  <= bfa_pkg::ST_IDLE;
            r_valid  <= '0;
            r_hint   <= '0;
            r_total  <= i_cfg.managed - 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hint   <= n_hint;
            r_total  <= n_total;
            r_strobe <= n_strobe;
            if (mem_we) begin
                r_valid[r_ptr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result  <= n_result;
        r_ptr     <= n_ptr;
        r_count   <= n_count;
        r_bitpos  <= n_bitpos;
        r_is_free <= n_is_free;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_ptr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

endmodule

// File: hw/rtl/bitmap_frame_allocator.sv
// First-fit page-frame allocator over a free bitmap held as 32-bit words in a
// single-port memory. A command is taken when start is high and busy is low;
// up to two commands wait in a queue, and busy is high while it is full.
// Results cannot be stalled: each appears for exactly one cycle with
// o_result_strobe high. An allocate of N frames pops the command, then for
// each frame reads a bitmap word, tests it and writes it back, giving N
// results; every fully used word skipped on the way adds another read and
// test. A free gives its one result after the same pop, read, test and write
// back, and a rejected command gives its result from the pop alone; a
// command that finds the back end still working waits in the queue first.
// The read-modify-write of one bitmap word paces each allocate and free. Writing the
// frame count register re-initializes the map in the following cycle through
// per-word written flags, with no clearing pass.
module bitmap_frame_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  bfa_pkg::t_bfa_request       i_request,
    output logic                        busy,
    input  logic                        i_cfg_we,
    input  logic [bfa_pkg::REG_W-1:0]   i_cfg_wdata,
    output logic                        o_result_strobe,
    output bfa_pkg::t_bfa_result        o_result
);

    logic [bfa_pkg::REG_W-1:0] r_managed;
    logic                      r_init;
    bfa_pkg::t_bfa_cfg         cfg;
    logic                      q_empty;
    logic                      q_pop;
    bfa_pkg::t_bfa_cmd         q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_managed <= bfa_pkg::clamp_frames(bfa_pkg::RESET_FRAMES,
                                               bfa_pkg::FRAME_COUNT);
            r_init    <= 1'b0;
        end else begin
            r_init <= i_cfg_we;
            if (i_cfg_we) begin
                r_managed <= bfa_pkg::clamp_frames(i_cfg_wdata, bfa_pkg::FRAME_COUNT);
            end
        end
    end

    assign cfg.init    = r_init;
    assign cfg.managed = r_managed;

    bfa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_request (i_request),
        .busy      (busy),
        .i_cfg     (cfg),
        .i_pop     (q_pop),
        .o_empty   (q_empty),
        .o_head    (q_head)
    );

    bfa_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_empty         (q_empty),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

// File: hw/rtl/bfa_checker.sv
module bfa_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_result_strobe,
    input bfa_pkg::t_bfa_result o_result
);

    // a failed transaction always ends its request
    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_result.status != bfa_pkg::STATUS_OK |-> o_result.last)
        else $error("failure result without last");

    a_status_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> o_result.status == bfa_pkg::STATUS_OK ||
                            o_result.status == bfa_pkg::STATUS_SHORT ||
                            o_result.status == bfa_pkg::STATUS_BAD)
        else $error("undefined status code");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_result.status != bfa_pkg::STATUS_OK |->
            o_result.frame_address == '0)
        else $error("failure result carries an address");

    // a non-final result is an allocated frame, never frame zero
    a_mid_is_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_result.last |->
            o_result.status == bfa_pkg::STATUS_OK && o_result.frame_address != '0)
        else $error("mid-request result is not a frame");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_result_strobe (o_result_strobe),
    .o_result        (o_result)
);

// File: dv/tb_top.sv
module tb_top;

    localparam int FRAMES = bfa_pkg::FRAME_COUNT;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    bfa_pkg::t_bfa_request     i_request = '0;
    logic                      busy;
    logic                      i_cfg_we = 1'b0;
    logic [bfa_pkg::REG_W-1:0] i_cfg_wdata = '0;
    logic                      o_result_strobe;
    bfa_pkg::t_bfa_result      o_result;

    bitmap_frame_allocator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_request       (i_request),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // shadow of the allocator: free bitmap, free counter, managed frame count
    logic [FRAMES-1:0] free_bits;
    int unsigned       free_frames;
    int unsigned       managed;

    bfa_pkg::t_bfa_request requests_to_send[$];
    bfa_pkg::t_bfa_result  frame_results_due[$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int requests_taken = 0;
    int settings_used  = 1;
    int burst_left     = 0;
    int gap_left       = 0;

    task automatic queue_request(input bfa_pkg::t_bfa_request req);
        requests_to_send.insert(requests_to_send.size(), req);
    endtask

    task automatic expect_result(input bfa_pkg::t_bfa_result res);
        frame_results_due.insert(frame_results_due.size(), res);
    endtask

    task automatic load_frame_count(input logic [bfa_pkg::REG_W-1:0] value);
        managed = value;
        if (managed < 2) managed = 2;
        if (managed > FRAMES) managed = FRAMES;
        free_bits = '0;
        for (int f = 1; f < managed; f++) free_bits[f] = 1'b1;
        free_frames = managed - 1;
    endtask

    task automatic grant_or_release(input bfa_pkg::t_bfa_request req);
        bfa_pkg::t_bfa_result res;
        int unsigned want;
        int unsigned frame;
        res = '0;
        res.last = 1'b1;
        if (req.opcode == bfa_pkg::OP_ALLOC) begin
            want = req.request_count;
            if (want > bfa_pkg::MAX_REQUEST || want > free_frames) begin
                res.status = bfa_pkg::STATUS_SHORT;
                res.free_count = bfa_pkg::COUNT_W'(free_frames);
                expect_result(res);
            end else if (want == 0) begin
                res.status = bfa_pkg::STATUS_OK;
                res.free_count = bfa_pkg::COUNT_W'(free_frames);
                expect_result(res);
            end else begin
                for (int k = 0; k < want; k++) begin
                    frame = 0;
                    for (int f = managed - 1; f >= 1; f--)
                        if (free_bits[f]) frame = f;
                    free_bits[frame] = 1'b0;
                    free_frames--;
                    res.status = bfa_pkg::STATUS_OK;
                    res.frame_address = bfa_pkg::ADDR_W'(frame << bfa_pkg::FRAME_SHIFT);
                    res.free_count = bfa_pkg::COUNT_W'(free_frames);
                    res.last = (k == want - 1);
                    expect_result(res);
                end
            end
        end else begin
            frame = req.free_address >> bfa_pkg::FRAME_SHIFT;
            if (frame == 0 || frame >= managed) begin
                res.status = bfa_pkg::STATUS_BAD;
            end else begin
                // freeing a frame that is already free leaves the counter alone
                if (!free_bits[frame]) begin
                    free_bits[frame] = 1'b1;
                    free_frames++;
                end
                res.status = bfa_pkg::STATUS_OK;
            end
            res.free_count = bfa_pkg::COUNT_W'(free_frames);
            expect_result(res);
        end
    endtask

    function automatic bfa_pkg::t_bfa_request alloc_req(input int unsigned n);
        bfa_pkg::t_bfa_request r;
        r.opcode = bfa_pkg::OP_ALLOC;
        r.request_count = bfa_pkg::REQ_W'(n);
        r.free_address = bfa_pkg::ADDR_W'($urandom);
        return r;
    endfunction

    function automatic bfa_pkg::t_bfa_request free_req(
        input logic [bfa_pkg::ADDR_W-1:0] addr);
        bfa_pkg::t_bfa_request r;
        r.opcode = bfa_pkg::OP_FREE;
        r.request_count = bfa_pkg::REQ_W'($urandom);
        r.free_address = addr;
        return r;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin : drive
        bfa_pkg::t_bfa_request nxt_req;
        logic                  nxt_start;
        nxt_req = i_request;
        nxt_start = start;
        if (start && !busy) begin
            grant_or_release(i_request);
            requests_taken++;
            nxt_start = 1'b0;
        end
        if (!nxt_start) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (requests_to_send.size() > 0) begin
                nxt_req = requests_to_send.pop_front();
                nxt_start = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                               : $urandom_range(1, 10);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
        end
        start <= nxt_start;
        i_request <= nxt_req;
    end

    always @(posedge i_clk) begin : watch
        bfa_pkg::t_bfa_result want;
        if (o_result_strobe) begin
            results_seen++;
            if (frame_results_due.size() == 0) begin
                $display("%0t: unexpected result status=%0d addr=%h free=%0d last=%0b",
                         $time, o_result.status, o_result.frame_address,
                         o_result.free_count, o_result.last);
                mismatch_count++;
            end else begin
                want = frame_results_due.pop_front();
                if (o_result !== want) begin
                    $display("%0t: expected status=%0d addr=%h free=%0d last=%0b",
                             $time, want.status, want.frame_address, want.free_count,
                             want.last);
                    $display("%0t:   actual status=%0d addr=%h free=%0d last=%0b",
                             $time, o_result.status, o_result.frame_address,
                             o_result.free_count, o_result.last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (requests_to_send.size() != 0 || start || frame_results_due.size() != 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_frame_count(input logic [bfa_pkg::REG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= ~value;
        load_frame_count(value);
        settings_used++;
    endtask

    task automatic queue_random(input int n);
        int unsigned hw;
        int unsigned pick;
        int unsigned cnt;
        hw = 1;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 5);
                queue_request(alloc_req(cnt));
                hw = hw + cnt;
                if (hw > managed - 1) hw = managed - 1;
            end else if (pick < 88) begin
                // mostly release frames that recent allocations probably took
                cnt = $urandom_range(1, hw);
                queue_request(free_req(bfa_pkg::ADDR_W'(cnt << bfa_pkg::FRAME_SHIFT) |
                                       bfa_pkg::ADDR_W'($urandom_range(0, 1023))));
            end else begin
                queue_request(free_req(bfa_pkg::ADDR_W'($urandom)));
            end
        end
    endtask

    initial begin : stimulus
        logic [bfa_pkg::REG_W-1:0] settings[7];
        settings = '{9'd0, 9'd511, 9'd2, 9'd33, 9'd256, 9'd257, 9'd100};
        load_frame_count(bfa_pkg::RESET_FRAMES);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed transactions on the reset frame count
        queue_request(alloc_req(0));
        queue_request(alloc_req(1));
        queue_request(alloc_req(64));
        queue_request(alloc_req(65));
        queue_request(alloc_req(127));
        queue_request(free_req(18'h00000));
        queue_request(free_req(18'h003FF));
        queue_request(free_req(18'h3FFFF));
        queue_request(free_req(18'h007FF));
        queue_request(free_req(18'h00400));
        queue_request(alloc_req(1));
        queue_request(alloc_req(64));
        queue_request(alloc_req(64));
        queue_request(alloc_req(64));
        queue_request(alloc_req(61));
        queue_request(alloc_req(1));
        queue_request(alloc_req(0));
        queue_request(free_req(bfa_pkg::ADDR_W'(200 << bfa_pkg::FRAME_SHIFT)));
        queue_request(free_req(bfa_pkg::ADDR_W'(130 << bfa_pkg::FRAME_SHIFT)));
        queue_request(alloc_req(2));
        queue_request(free_req(18'h3FC00));
        queue_request(alloc_req(2));
        queue_request(free_req(18'h3FFFF));
        wait_quiet();

        foreach (settings[s]) begin
            write_frame_count(settings[s]);
            // out-of-range frame right after the map edge
            queue_request(free_req(bfa_pkg::ADDR_W'(managed << bfa_pkg::FRAME_SHIFT)));
            queue_random(47);
            wait_quiet();
        end

        $display("%0d transactions over %0d frame-count settings, %0d results checked",
                 requests_taken, settings_used, results_seen);
        if (mismatch_count == 0 && frame_results_due.size() == 0) begin
            $display("[bitmap_frame_allocator] OK");
        end else begin
            $display("[bitmap_frame_allocator] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #25_000_000;
        $display("timeout with %0d results outstanding", frame_results_due.size());
        $display("[bitmap_frame_allocator] ERROR");
        $finish;
    end

endmodule
